// ----- rtl/core/twmc_pkg.sv -----
// ----------------------------------------------------------------------------
// twmc_pkg
// types, codes and constant tables for the world matrix compose core
// ----------------------------------------------------------------------------
package twmc_pkg;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } t_out_item;

    // operation codes
    localparam logic [2:0] OP_SET_POS = 3'd0;
    localparam logic [2:0] OP_ADD_POS = 3'd1;
    localparam logic [2:0] OP_SET_ROT = 3'd2;
    localparam logic [2:0] OP_ADD_ROT = 3'd3;
    localparam logic [2:0] OP_SET_SCL = 3'd4;
    localparam logic [2:0] OP_ADD_SCL = 3'd5;

    // pi/2 in q32, and cordic start gain in q30
    localparam logic [32:0]        HALF_PI_Q32     = 33'd6746518852;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sh026DD3B6A;
    localparam logic signed [33:0] Q30_POS_ONE     = 34'sh040000000;
    localparam logic signed [33:0] Q30_NEG_ONE     = -34'sh040000000;
    localparam logic [4:0]         CORDIC_LAST     = 5'd31;

    // rotation matrix product program
    typedef enum logic [2:0] {
        OPD_CX, OPD_SX, OPD_CY, OPD_SY, OPD_CZ, OPD_SZ, OPD_SZSX, OPD_CZSX
    } t_opnd;

    typedef enum logic [1:0] {
        MODE_SET, MODE_ADD, MODE_SUB
    } t_mode;

    localparam logic [3:0] DST_R00  = 4'd0;
    localparam logic [3:0] DST_R01  = 4'd1;
    localparam logic [3:0] DST_R02  = 4'd2;
    localparam logic [3:0] DST_R10  = 4'd3;
    localparam logic [3:0] DST_R11  = 4'd4;
    localparam logic [3:0] DST_R12  = 4'd5;
    localparam logic [3:0] DST_R20  = 4'd6;
    localparam logic [3:0] DST_R21  = 4'd7;
    localparam logic [3:0] DST_R22  = 4'd8;
    localparam logic [3:0] DST_SZSX = 4'd9;
    localparam logic [3:0] DST_CZSX = 4'd10;

    localparam logic [3:0] ROT_LAST   = 4'd13;
    localparam logic [3:0] SCALE_LAST = 4'd8;

    typedef struct packed {
        t_opnd      a;
        t_opnd      b;
        logic [3:0] dst;
        t_mode      mode;
    } t_uop;

    function automatic t_uop twmc_uop(input logic [3:0] step);
        t_uop u;
        u = '{a: OPD_CX, b: OPD_CY, dst: DST_R22, mode: MODE_SET};
        case (step)
            4'd0:    u = '{a: OPD_SZ,   b: OPD_SX, dst: DST_SZSX, mode: MODE_SET};
            4'd1:    u = '{a: OPD_CZ,   b: OPD_SX, dst: DST_CZSX, mode: MODE_SET};
            4'd2:    u = '{a: OPD_CZ,   b: OPD_CY, dst: DST_R00,  mode: MODE_SET};
            4'd3:    u = '{a: OPD_SZSX, b: OPD_SY, dst: DST_R00,  mode: MODE_ADD};
            4'd4:    u = '{a: OPD_SZ,   b: OPD_CX, dst: DST_R01,  mode: MODE_SET};
            4'd5:    u = '{a: OPD_SZSX, b: OPD_CY, dst: DST_R02,  mode: MODE_SET};
            4'd6:    u = '{a: OPD_CZ,   b: OPD_SY, dst: DST_R02,  mode: MODE_SUB};
            4'd7:    u = '{a: OPD_CZSX, b: OPD_SY, dst: DST_R10,  mode: MODE_SET};
            4'd8:    u = '{a: OPD_SZ,   b: OPD_CY, dst: DST_R10,  mode: MODE_SUB};
            4'd9:    u = '{a: OPD_CZ,   b: OPD_CX, dst: DST_R11,  mode: MODE_SET};
            4'd10:   u = '{a: OPD_SZ,   b: OPD_SY, dst: DST_R12,  mode: MODE_SET};
            4'd11:   u = '{a: OPD_CZSX, b: OPD_CY, dst: DST_R12,  mode: MODE_ADD};
            4'd12:   u = '{a: OPD_CX,   b: OPD_SY, dst: DST_R20,  mode: MODE_SET};
            4'd13:   u = '{a: OPD_CX,   b: OPD_CY, dst: DST_R22,  mode: MODE_SET};
            default: u = '{a: OPD_CX,   b: OPD_CY, dst: DST_R22,  mode: MODE_SET};
        endcase
        return u;
    endfunction

    // atan(2^-i) in q32, rounded
    function automatic logic [31:0] twmc_atan(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd3373259426;
            5'd1:    v = 32'd1991351318;
            5'd2:    v = 32'd1052175346;
            5'd3:    v = 32'd534100635;
            5'd4:    v = 32'd268086748;
            5'd5:    v = 32'd134174063;
            5'd6:    v = 32'd67103403;
            5'd7:    v = 32'd33553749;
            5'd8:    v = 32'd16777131;
            5'd9:    v = 32'd8388597;
            5'd10:   v = 32'd4194303;
            default: v = 32'd1 << (6'd32 - {1'b0, i});
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] twmc_sat_add(
        input logic signed [31:0] a,
        input logic signed [31:0] b
    );
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'sh07FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (s < -33'sh080000000) begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] twmc_sat32(input logic signed [35:0] v);
        if (v > 36'sh07FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < -36'sh080000000) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- rtl/core/trs_world_matrix_compose_core.sv -----
// ----------------------------------------------------------------------------
// trs_world_matrix_compose_core
// keeps position, euler rotation and scale, and emits the affine world matrix
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
//  one transaction in gives one transaction out
//  per axis: one restoring compare-subtract step per quotient bit for angle
//  reduction, then the iterations of the shared cordic stage
//  then 23 products through one shared multiplier, each in S_MUL then S_ACC
//  o_in_stall is high from acceptance until the result transaction is taken
//  reset is synchronous, active low; state vectors return to zero and unit scale
//
module trs_world_matrix_compose_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  twmc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output twmc_pkg::t_out_item o_out_data
);
    import twmc_pkg::*;

    // reduction width holds |angle| widened to q32
    localparam int W_RED  = 64 - FRAC_BITS;
    localparam int DIV_N  = 31 - FRAC_BITS;
    localparam int W_CNT  = $clog2(DIV_N + 1);
    localparam int ANG_SH = 32 - FRAC_BITS;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LOAD = 9'b000000010,
        S_RED  = 9'b000000100,
        S_QUAD = 9'b000001000,
        S_ROT  = 9'b000010000,
        S_MAP  = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_ACC  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // transform state
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_rot [3];
    logic signed [31:0] r_scl [3];

    // angle reduction
    logic [1:0]       r_axis;
    logic             r_neg;
    logic [W_RED-1:0] r_rem;
    logic [1:0]       r_q;
    logic [W_CNT-1:0] r_cnt;

    // cordic
    logic signed [33:0] r_x, r_y;
    logic signed [35:0] r_z;
    logic [4:0]         r_it;
    logic [1:0]         r_k;
    logic signed [31:0] r_cos [3];
    logic signed [31:0] r_sin [3];

    // product phase
    logic signed [31:0] r_szsx, r_czsx;
    logic signed [32:0] r_r [9];
    logic signed [65:0] r_prod;
    logic [3:0]         r_step;
    logic [1:0]         r_row, r_col;
    logic               r_scale_ph;
    logic signed [31:0] r_mat [9];

    logic               in_acc;
    logic signed [31:0] in_vec [3];

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_acc      = i_in_valid && !o_in_stall;

    assign in_vec[0] = i_in_data.value_x;
    assign in_vec[1] = i_in_data.value_y;
    assign in_vec[2] = i_in_data.value_z;

    // reduction step: compare against half pi shifted to the current quotient bit
    logic [W_RED-1:0] hp_sh;
    logic             red_ge;
    logic [31:0]      ang_mag;
    logic signed [31:0] ang_cur;

    assign ang_cur = r_rot[r_axis];
    assign ang_mag = ang_cur[31] ? (~ang_cur + 32'd1) : ang_cur;
    assign hp_sh   = W_RED'(HALF_PI_Q32) << r_cnt;
    assign red_ge  = (r_rem >= hp_sh);

    // quadrant and remainder in [0, pi/2) from the magnitude's quotient
    logic [32:0] zm;
    logic [32:0] z_fix;
    logic [1:0]  k_fix;

    always_comb begin
        zm = r_rem[32:0];
        if (!r_neg) begin
            k_fix = r_q;
            z_fix = zm;
        end else if (zm == 33'd0) begin
            k_fix = ~r_q + 2'd1;
            z_fix = 33'd0;
        end else begin
            k_fix = ~r_q;
            z_fix = HALF_PI_Q32 - zm;
        end
    end

    // shared cordic stage
    logic signed [33:0] cdx, cdy;
    logic signed [35:0] catan;

    assign cdx   = r_y >>> r_it;
    assign cdy   = r_x >>> r_it;
    assign catan = $signed({4'b0000, twmc_atan(r_it)});

    // quadrant map and clamp to unit
    logic signed [33:0] map_c, map_s;
    logic signed [31:0] cl_c, cl_s;

    always_comb begin
        case (r_k)
            2'd0:    begin map_c = r_x;  map_s = r_y;  end
            2'd1:    begin map_c = -r_y; map_s = r_x;  end
            2'd2:    begin map_c = -r_x; map_s = -r_y; end
            default: begin map_c = r_y;  map_s = -r_x; end
        endcase
        if (map_c > Q30_POS_ONE)      cl_c = Q30_POS_ONE[31:0];
        else if (map_c < Q30_NEG_ONE) cl_c = Q30_NEG_ONE[31:0];
        else                          cl_c = map_c[31:0];
        if (map_s > Q30_POS_ONE)      cl_s = Q30_POS_ONE[31:0];
        else if (map_s < Q30_NEG_ONE) cl_s = Q30_NEG_ONE[31:0];
        else                          cl_s = map_s[31:0];
    end

    // shared multiplier operands
    t_uop               uop;
    logic signed [32:0] mul_a, mul_b;

    function automatic logic signed [31:0] pick(input t_opnd sel);
        logic signed [31:0] v;
        case (sel)
            OPD_CX:   v = r_cos[0];
            OPD_SX:   v = r_sin[0];
            OPD_CY:   v = r_cos[1];
            OPD_SY:   v = r_sin[1];
            OPD_CZ:   v = r_cos[2];
            OPD_SZ:   v = r_sin[2];
            OPD_SZSX: v = r_szsx;
            OPD_CZSX: v = r_czsx;
            default:  v = r_szsx;
        endcase
        return v;
    endfunction

    assign uop = twmc_uop(r_step);

    always_comb begin
        if (r_scale_ph) begin
            mul_a = 33'(r_scl[r_row]);
            mul_b = r_r[r_step];
        end else begin
            mul_a = 33'(pick(uop.a));
            mul_b = 33'(pick(uop.b));
        end
    end

    // round a q30-scaled product back by 30 bits
    logic signed [65:0] rsum;
    logic signed [35:0] rnd;
    logic signed [32:0] term;

    assign rsum = r_prod + 66'sd536870912;
    assign rnd  = rsum[65:30];
    assign term = rnd[32:0];

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_LOAD;
            S_LOAD: n_state = S_RED;
            S_RED:  if (r_cnt == W_CNT'(0)) n_state = S_QUAD;
            S_QUAD: n_state = S_ROT;
            S_ROT:  if (r_it == CORDIC_LAST) n_state = S_MAP;
            S_MAP:  n_state = (r_axis == 2'd2) ? S_MUL : S_LOAD;
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = (r_scale_ph && r_step == SCALE_LAST) ? S_OUT : S_MUL;
            S_OUT:  if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_axis     <= 2'd0;
            r_scale_ph <= 1'b0;
            r_step     <= 4'd0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_rot[i] <= '0;
                r_scl[i] <= 32'(1) << FRAC_BITS;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_axis     <= 2'd0;
                        r_scale_ph <= 1'b0;
                        r_step     <= 4'd0;
                        for (int i = 0; i < 3; i++) begin
                            case (i_in_data.operation)
                                OP_SET_POS: r_pos[i] <= in_vec[i];
                                OP_ADD_POS: r_pos[i] <= twmc_sat_add(r_pos[i], in_vec[i]);
                                OP_SET_ROT: r_rot[i] <= in_vec[i];
                                OP_ADD_ROT: r_rot[i] <= twmc_sat_add(r_rot[i], in_vec[i]);
                                OP_SET_SCL: r_scl[i] <= in_vec[i];
                                OP_ADD_SCL: r_scl[i] <= twmc_sat_add(r_scl[i], in_vec[i]);
                                default: ;
                            endcase
                        end
                    end
                end
                S_LOAD: begin
                    r_neg <= ang_cur[31];
                    r_rem <= W_RED'(ang_mag) << ANG_SH;
                    r_cnt <= W_CNT'(DIV_N);
                    r_q   <= 2'd0;
                end
                S_RED: begin
                    if (red_ge) r_rem <= r_rem - hp_sh;
                    r_q   <= {r_q[0], red_ge};
                    r_cnt <= r_cnt - W_CNT'(1);
                end
                S_QUAD: begin
                    r_k  <= k_fix;
                    r_z  <= $signed({3'b000, z_fix});
                    r_x  <= CORDIC_GAIN_Q30;
                    r_y  <= '0;
                    r_it <= 5'd0;
                end
                S_ROT: begin
                    if (!r_z[35]) begin
                        r_x <= r_x - cdx;
                        r_y <= r_y + cdy;
                        r_z <= r_z - catan;
                    end else begin
                        r_x <= r_x + cdx;
                        r_y <= r_y - cdy;
                        r_z <= r_z + catan;
                    end
                    r_it <= r_it + 5'd1;
                end
                S_MAP: begin
                    r_cos[r_axis] <= cl_c;
                    r_sin[r_axis] <= cl_s;
                    if (r_axis == 2'd2) begin
                        // row 2 column 1 is just minus sin x
                        r_r[DST_R21] <= -33'(r_sin[0]);
                        r_step       <= 4'd0;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                S_MUL: begin
                    r_prod <= mul_a * mul_b;
                end
                S_ACC: begin
                    if (r_scale_ph) begin
                        r_mat[r_step] <= twmc_sat32(rnd);
                        r_step        <= r_step + 4'd1;
                        if (r_col == 2'd2) begin
                            r_col <= 2'd0;
                            r_row <= r_row + 2'd1;
                        end else begin
                            r_col <= r_col + 2'd1;
                        end
                    end else begin
                        if (uop.dst == DST_SZSX) begin
                            r_szsx <= rnd[31:0];
                        end else if (uop.dst == DST_CZSX) begin
                            r_czsx <= rnd[31:0];
                        end else begin
                            case (uop.mode)
                                MODE_ADD: r_r[uop.dst] <= r_r[uop.dst] + term;
                                MODE_SUB: r_r[uop.dst] <= r_r[uop.dst] - term;
                                default:  r_r[uop.dst] <= term;
                            endcase
                        end
                        if (r_step == ROT_LAST) begin
                            r_scale_ph <= 1'b1;
                            r_step     <= 4'd0;
                            r_row      <= 2'd0;
                            r_col      <= 2'd0;
                        end else begin
                            r_step <= r_step + 4'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result transaction: matrix entries and stored position
    assign o_out_data.m00 = r_mat[0];
    assign o_out_data.m01 = r_mat[1];
    assign o_out_data.m02 = r_mat[2];
    assign o_out_data.m10 = r_mat[3];
    assign o_out_data.m11 = r_mat[4];
    assign o_out_data.m12 = r_mat[5];
    assign o_out_data.m20 = r_mat[6];
    assign o_out_data.m21 = r_mat[7];
    assign o_out_data.m22 = r_mat[8];
    assign o_out_data.tx  = r_pos[0];
    assign o_out_data.ty  = r_pos[1];
    assign o_out_data.tz  = r_pos[2];

    // an accepted transaction always starts angle reduction next
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_LOAD))
        else $error("accepted transaction did not start reduction");

    // the result only appears right after the last scale product
    a_out_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_ACC && $past(r_scale_ph)))
        else $error("result shown without finishing the scale products");

    // cordic start only after the full set of reduction steps
    a_quad_after_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QUAD) |-> ($past(r_state) == S_RED && r_cnt == {W_CNT{1'b1}}))
        else $error("reduction cut short");

    // scale phase never indexes past the nine entries
    a_scale_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_scale_ph) |-> (r_step <= SCALE_LAST))
        else $error("scale step out of range");

endmodule
